// ===== hdl/imu_complementary_attitude_filter_unit_macros.svh =====
// Assertion macros used by the checker file of the attitude filter.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_UNIT_MACROS_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_UNIT_MACROS_SVH

// Checked only while reset is released.
`define IMU_CAF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define IMU_CAF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/imu_caf_pkg.sv =====
`default_nettype none
package imu_caf_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int CORDIC_ITER_DEF = 16;
    localparam int ATAN_LEN = 24;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam logic [15:0] ALPHA_DEFAULT = 16'd64225;
    localparam longint GYRO_DIV = 64'sd512000000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [15:0]        step_us;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [31:0] yaw_angle;
        logic [31:0]        sample_count;
        logic               updated;
    } t_out_item;

    // One queued item together with its class.
    typedef struct packed {
        logic     upd;
        t_in_item item;
    } t_cmd;

    // Arctangent of 2^-i in radians, Q30, truncated.
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/imu_complementary_attitude_filter_unit.sv =====
`default_nettype none
// Roll, pitch and yaw estimator for one six-axis IMU sample per item.
// Input channel: i_in_valid / o_in_stall with i_in_data; an item is taken at
// an edge where valid is high and stall is low. A two-entry queue sits in
// front, so up to two items are taken while the core is busy; an item
// taken into an empty queue is at the queue head in the cycle after.
// Output channel: o_out_valid / i_out_stall with o_out_data, from a result
// register; one result item per input item, in order.
// Blend weight: write i_cfg_wdata with i_cfg_we high while the block is idle.
// A sample with a nonzero time step holds the core through the accelerometer
// angle unit (two CORDIC passes and a square root), which sets the pace; the
// gyro step unit (multiply, reciprocal, check, output per axis) runs beside
// it. Then come the handoff, the blend of each angle (multiply, multiply-add,
// round, wrap), the load of the result and an idle state, where the result is
// valid while the next item, if any, leaves the queue. A zero time step item
// goes from idle straight to the result load; one item at a time.
// Reset (synchronous, active low) zeroes the angles, yaw and count, sets the
// blend weight to 0.98 and empties the queue. While the receiver stalls, the
// result holds and the core finishes at most one more item; the queue then
// fills and stalls the sender.
module imu_complementary_attitude_filter_unit import imu_caf_pkg::*; #(
    parameter int ANGLE_FRAC_BITS   = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int SW = ANGLE_FRAC_BITS + 4;

    logic              w_q_valid;
    t_cmd              w_q_cmd;
    logic              w_q_pop;
    logic              w_start;
    logic signed [SW-1:0] w_step_x;
    logic signed [SW-1:0] w_step_y;
    logic signed [SW-1:0] w_step_z;
    logic              w_gyro_done;
    logic signed [SW-1:0] w_acc_roll;
    logic signed [SW-1:0] w_acc_pitch;
    logic              w_tilt_done;

    imu_caf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd),
        .i_q_pop    (w_q_pop)
    );

    imu_caf_gstep #(
        .FRAC (ANGLE_FRAC_BITS)
    ) u_gstep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_gx     (w_q_cmd.item.gyro_x),
        .i_gy     (w_q_cmd.item.gyro_y),
        .i_gz     (w_q_cmd.item.gyro_z),
        .i_us     (w_q_cmd.item.step_us),
        .o_step_x (w_step_x),
        .o_step_y (w_step_y),
        .o_step_z (w_step_z),
        .o_done   (w_gyro_done)
    );

    imu_caf_tilt #(
        .FRAC (ANGLE_FRAC_BITS),
        .ITER (CORDIC_ITERATIONS)
    ) u_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ax    (w_q_cmd.item.accel_x),
        .i_ay    (w_q_cmd.item.accel_y),
        .i_az    (w_q_cmd.item.accel_z),
        .o_roll  (w_acc_roll),
        .o_pitch (w_acc_pitch),
        .o_done  (w_tilt_done)
    );

    imu_caf_back #(
        .FRAC (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .o_start     (w_start),
        .i_step_x    (w_step_x),
        .i_step_y    (w_step_y),
        .i_step_z    (w_step_z),
        .i_gyro_done (w_gyro_done),
        .i_acc_roll  (w_acc_roll),
        .i_acc_pitch (w_acc_pitch),
        .i_tilt_done (w_tilt_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== hdl/imu_caf_front.sv =====
`default_nettype none
module imu_caf_front import imu_caf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_q_valid,
    output t_cmd          o_q_cmd,
    input  wire logic     i_q_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_q[r_rp];

    // A zero time step marks an item that only reports the state.
    always_comb begin
        w_cmd.item = i_in_data;
        w_cmd.upd  = (i_in_data.step_us != 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/imu_caf_gstep.sv =====
`default_nettype none
module imu_caf_gstep import imu_caf_pkg::*; #(
    parameter int FRAC = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_gx,
    input  wire logic signed [15:0] i_gy,
    input  wire logic signed [15:0] i_gz,
    input  wire logic [15:0]        i_us,
    output logic signed [FRAC+3:0]  o_step_x,
    output logic signed [FRAC+3:0]  o_step_y,
    output logic signed [FRAC+3:0]  o_step_z,
    output logic                    o_done
);

    localparam int SW = FRAC + 4;
    localparam int QW = FRAC + 3;
    localparam int NW = FRAC + 32;
    localparam int DSH = 15;
    localparam int KW = NW - DSH;
    localparam int MW = KW - 13;
    localparam int PW = KW + MW;
    localparam longint DODD = GYRO_DIV >>> DSH;
    localparam logic [NW-1:0] HALF_D = NW'(GYRO_DIV / 2);
    localparam logic [KW-1:0] D_K = KW'(DODD);
    localparam logic [MW-1:0] M_REC = MW'((64'sd1 <<< KW) / DODD);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_REC  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           r_st;
    logic [1:0]           r_axis;
    logic signed [15:0]   r_gx;
    logic signed [15:0]   r_gy;
    logic signed [15:0]   r_gz;
    logic [15:0]          r_us;
    logic                 r_neg;
    logic [KW-1:0]        r_n;
    logic [MW-1:0]        r_qe;
    logic                 r_fix;
    logic signed [SW-1:0] r_sx;
    logic signed [SW-1:0] r_sy;
    logic signed [SW-1:0] r_sz;
    logic                 r_done;

    logic signed [15:0]   w_rate;
    logic [15:0]          w_mag;
    logic [31:0]          w_prod;
    logic [NW-1:0]        w_num;
    logic [PW-1:0]        w_full;
    logic [KW-1:0]        w_qd;
    logic [QW-1:0]        w_q;
    logic signed [SW-1:0] w_step;

    // The divisor is 2^15 times an odd part. The power of two is a shift; the
    // odd part is a reciprocal multiplication that is low by at most one,
    // fixed by one compare of the remainder.
    always_comb begin
        case (r_axis)
            2'd0:    w_rate = r_gx;
            2'd1:    w_rate = r_gy;
            default: w_rate = r_gz;
        endcase
        w_mag  = w_rate[15] ? 16'(-w_rate) : w_rate;
        w_prod = w_mag * r_us;
        w_num  = ((NW'(w_prod) << FRAC) + HALF_D) >> DSH;
        w_full = PW'(r_n) * PW'(M_REC);
        w_qd   = KW'(r_qe) * D_K;
        w_q    = QW'(r_qe) + QW'(r_fix);
        w_step = r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    end

    assign o_step_x = r_sx;
    assign o_step_y = r_sy;
    assign o_step_z = r_sz;
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                if (i_start) begin
                    r_gx <= i_gx;
                    r_gy <= i_gy;
                    r_gz <= i_gz;
                    r_us <= i_us;
                end
            end
            ST_MUL: begin
                r_n   <= w_num[KW-1:0];
                r_neg <= w_rate[15];
            end
            ST_REC: begin
                r_qe <= w_full[PW-1:KW];
            end
            ST_CHK: begin
                r_fix <= ((r_n - w_qd) >= D_K);
            end
            ST_OUT: begin
                case (r_axis)
                    2'd0:    r_sx <= w_step;
                    2'd1:    r_sy <= w_step;
                    default: r_sz <= w_step;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_axis <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_start) begin
                        r_axis <= 2'd0;
                        r_st   <= ST_MUL;
                    end
                end
                ST_MUL: r_st <= ST_REC;
                ST_REC: r_st <= ST_CHK;
                ST_CHK: r_st <= ST_OUT;
                ST_OUT: begin
                    if (r_axis == 2'd2) begin
                        r_done <= 1'b1;
                        r_st   <= ST_IDLE;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                        r_st   <= ST_MUL;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/imu_caf_tilt.sv =====
`default_nettype none
module imu_caf_tilt import imu_caf_pkg::*; #(
    parameter int FRAC = ANGLE_FRAC_BITS_DEF,
    parameter int ITER = CORDIC_ITER_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_ax,
    input  wire logic signed [15:0] i_ay,
    input  wire logic signed [15:0] i_az,
    output logic signed [FRAC+3:0]  o_roll,
    output logic signed [FRAC+3:0]  o_pitch,
    output logic                    o_done
);

    localparam int NIT = (ITER < ATAN_LEN) ? ITER : ATAN_LEN;
    localparam int OW = FRAC + 4;
    localparam int CW = 35;
    localparam int ZW = 34;
    localparam int RS = 30 - FRAC;
    localparam logic signed [ZW-1:0] PI_Z = ZW'(PI_Q30);
    localparam logic [ZW-1:0] HALF_Z = ZW'(64'd1 << (RS - 1));

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_ROLL  = 3'd2;
    localparam logic [2:0] ST_RFIN  = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_PLOAD = 3'd5;
    localparam logic [2:0] ST_PITCH = 3'd6;
    localparam logic [2:0] ST_PFIN  = 3'd7;

    logic [2:0]           r_st;
    logic [4:0]           r_it;
    logic signed [15:0]   r_ax;
    logic signed [15:0]   r_ay;
    logic signed [15:0]   r_az;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_zero;
    logic [31:0]          r_sqa;
    logic [31:0]          r_sqb;
    logic [31:0]          r_v;
    logic [31:0]          r_r;
    logic [31:0]          r_bit;
    logic signed [OW-1:0] r_roll;
    logic signed [OW-1:0] r_pitch;
    logic                 r_done;

    logic signed [31:0]   w_sqa;
    logic signed [31:0]   w_sqb;
    logic signed [17:0]   w_yin;
    logic signed [17:0]   w_xin;
    logic signed [17:0]   w_xabs;
    logic signed [17:0]   w_yadj;
    logic signed [CW-1:0] w_x0;
    logic signed [CW-1:0] w_y0;
    logic signed [ZW-1:0] w_z0;
    logic                 w_zero;
    logic signed [CW-1:0] w_sx;
    logic signed [CW-1:0] w_sy;
    logic signed [ZW-1:0] w_at;
    logic [ZW-1:0]        w_zabs;
    logic [ZW-1:0]        w_zq;
    logic signed [OW-1:0] w_ang;
    logic [32:0]          w_trial;
    logic                 w_take;

    assign w_sqa = r_ay * r_ay;
    assign w_sqb = r_az * r_az;

    // Operand setup: a negative x folds into the half plane x >= 0 plus or minus pi.
    always_comb begin
        if (r_st == ST_PLOAD) begin
            w_yin = -18'(r_ax);
            w_xin = 18'(r_r);
        end else begin
            w_yin = 18'(r_ay);
            w_xin = 18'(r_az);
        end
        w_zero = (w_xin == 18'sd0) && (w_yin == 18'sd0);
        if (w_xin < 0) begin
            w_xabs = -w_xin;
            w_yadj = -w_yin;
            w_z0   = (w_yin >= 0) ? PI_Z : -PI_Z;
        end else begin
            w_xabs = w_xin;
            w_yadj = w_yin;
            w_z0   = '0;
        end
        w_x0 = CW'(w_xabs) <<< 16;
        w_y0 = CW'(w_yadj) <<< 16;
    end

    always_comb begin
        w_sx   = r_x >>> r_it;
        w_sy   = r_y >>> r_it;
        w_at   = $signed({2'b00, atan_q30(r_it)});
        w_zabs = r_z[ZW-1] ? 34'(-r_z) : 34'(r_z);
        w_zq   = (w_zabs + HALF_Z) >> RS;
        w_ang  = r_zero ? '0 : OW'(r_z[ZW-1] ? -w_zq : w_zq);
        w_trial = {1'b0, r_r} + {1'b0, r_bit};
        w_take  = ({1'b0, r_v} >= w_trial);
    end

    assign o_roll  = r_roll;
    assign o_pitch = r_pitch;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                if (i_start) begin
                    r_ax <= i_ax;
                    r_ay <= i_ay;
                    r_az <= i_az;
                end
            end
            ST_PREP, ST_PLOAD: begin
                r_x    <= w_x0;
                r_y    <= w_y0;
                r_z    <= w_z0;
                r_zero <= w_zero;
                r_sqa  <= w_sqa;
                r_sqb  <= w_sqb;
            end
            ST_ROLL, ST_PITCH: begin
                if (r_y > 0) begin
                    r_x <= r_x + w_sy;
                    r_y <= r_y - w_sx;
                    r_z <= r_z + w_at;
                end else begin
                    r_x <= r_x - w_sy;
                    r_y <= r_y + w_sx;
                    r_z <= r_z - w_at;
                end
            end
            ST_RFIN: begin
                r_roll <= w_ang;
                r_v    <= r_sqa + r_sqb;
                r_r    <= '0;
                r_bit  <= 32'h4000_0000;
            end
            ST_SQRT: begin
                // Floor square root, one result bit per cycle.
                if (w_take) begin
                    r_v <= r_v - w_trial[31:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_PFIN: begin
                r_pitch <= w_ang;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_it   <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_start) begin
                        r_st <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_it <= '0;
                    r_st <= ST_ROLL;
                end
                ST_ROLL: begin
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'(NIT - 1)) begin
                        r_st <= ST_RFIN;
                    end
                end
                ST_RFIN: r_st <= ST_SQRT;
                ST_SQRT: begin
                    if (r_bit[0]) begin
                        r_st <= ST_PLOAD;
                    end
                end
                ST_PLOAD: begin
                    r_it <= '0;
                    r_st <= ST_PITCH;
                end
                ST_PITCH: begin
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'(NIT - 1)) begin
                        r_st <= ST_PFIN;
                    end
                end
                ST_PFIN: begin
                    r_done <= 1'b1;
                    r_st   <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/imu_caf_back.sv =====
`default_nettype none
module imu_caf_back import imu_caf_pkg::*; #(
    parameter int FRAC = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_wdata,
    input  wire logic              i_q_valid,
    input  wire t_cmd              i_q_cmd,
    output logic                   o_q_pop,
    output logic                   o_start,
    input  wire logic signed [FRAC+3:0] i_step_x,
    input  wire logic signed [FRAC+3:0] i_step_y,
    input  wire logic signed [FRAC+3:0] i_step_z,
    input  wire logic              i_gyro_done,
    input  wire logic signed [FRAC+3:0] i_acc_roll,
    input  wire logic signed [FRAC+3:0] i_acc_pitch,
    input  wire logic              i_tilt_done,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data
);

    localparam int AW = FRAC + 3;
    localparam int GW = FRAC + 5;
    localparam int PW = FRAC + 24;
    localparam int RW = PW - 16;
    localparam longint PI_F = (PI_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    localparam logic signed [RW-1:0] P_R = RW'(PI_F);
    localparam logic signed [RW-1:0] TP_R = RW'(2 * PI_F);
    localparam logic [PW-1:0] HALF16 = PW'(32768);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WAIT = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_WRAP = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]           r_st;
    logic [15:0]          r_alpha;
    logic signed [AW-1:0] r_roll;
    logic signed [AW-1:0] r_pitch;
    logic [31:0]          r_yaw;
    logic [31:0]          r_cnt;
    logic                 r_upd;
    logic                 r_gd;
    logic                 r_td;
    logic                 r_sel;
    logic signed [PW-1:0] r_acc;
    logic signed [RW-1:0] r_t;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [15:0]          w_a;
    logic signed [17:0]   w_as;
    logic signed [17:0]   w_bs;
    logic signed [GW-1:0] w_g;
    logic signed [AW:0]   w_accang;
    logic signed [PW-1:0] w_p1;
    logic signed [PW-1:0] w_p2;
    logic [PW-1:0]        w_abs;
    logic [PW-1:0]        w_q;
    logic signed [RW-1:0] w_wrap;
    logic                 w_emit;

    always_comb begin
        w_a  = (r_alpha == 16'd0) ? ALPHA_DEFAULT : r_alpha;
        w_as = $signed({2'b00, w_a});
        w_bs = $signed(18'h10000 - {2'b00, w_a});
        if (r_sel) begin
            w_g      = GW'(r_pitch) + GW'(i_step_y);
            w_accang = i_acc_pitch;
        end else begin
            w_g      = GW'(r_roll) + GW'(i_step_x);
            w_accang = i_acc_roll;
        end
        w_p1  = w_as * w_g;
        w_p2  = w_bs * w_accang;
        w_abs = r_acc[PW-1] ? PW'(-r_acc) : PW'(r_acc);
        w_q   = (w_abs + HALF16) >> 16;
        // Any blended value lies within one turn of the range.
        if (r_t > P_R) begin
            w_wrap = r_t - TP_R;
        end else if (r_t < -P_R) begin
            w_wrap = r_t + TP_R;
        end else begin
            w_wrap = r_t;
        end
        w_emit = (r_st == ST_EMIT) && (!r_out_valid || !i_out_stall);
    end

    assign o_q_pop     = (r_st == ST_IDLE) && i_q_valid;
    assign o_start     = o_q_pop && i_q_cmd.upd;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_M1:  r_acc <= w_p1;
            ST_M2:  r_acc <= r_acc + w_p2;
            ST_RND: r_t   <= RW'(r_acc[PW-1] ? -w_q : w_q);
            default: begin
            end
        endcase
        if (w_emit) begin
            r_out.roll_angle   <= 16'(r_roll);
            r_out.pitch_angle  <= 16'(r_pitch);
            r_out.yaw_angle    <= r_yaw;
            r_out.sample_count <= r_cnt;
            r_out.updated      <= r_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_alpha     <= ALPHA_DEFAULT;
            r_roll      <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_cnt       <= '0;
            r_upd       <= 1'b0;
            r_gd        <= 1'b0;
            r_td        <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_alpha <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_upd <= i_q_cmd.upd;
                        r_gd  <= 1'b0;
                        r_td  <= 1'b0;
                        r_st  <= i_q_cmd.upd ? ST_WAIT : ST_EMIT;
                    end
                end
                ST_WAIT: begin
                    r_gd <= r_gd || i_gyro_done;
                    r_td <= r_td || i_tilt_done;
                    if (r_gd && r_td) begin
                        r_sel <= 1'b0;
                        r_st  <= ST_M1;
                    end
                end
                ST_M1:  r_st <= ST_M2;
                ST_M2:  r_st <= ST_RND;
                ST_RND: r_st <= ST_WRAP;
                ST_WRAP: begin
                    if (r_sel) begin
                        r_pitch <= AW'(w_wrap);
                        r_yaw   <= r_yaw + 32'(i_step_z);
                        r_cnt   <= r_cnt + 32'd1;
                        r_st    <= ST_EMIT;
                    end else begin
                        r_roll <= AW'(w_wrap);
                        r_sel  <= 1'b1;
                        r_st   <= ST_M1;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/imu_caf_checker.sv =====
`default_nettype none
`include "imu_complementary_attitude_filter_unit_macros.svh"
module imu_caf_checker import imu_caf_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire t_out_item   o_out_data
);

    logic      r_have;
    t_out_item r_prev;
    logic      w_take;

    assign w_take = o_out_valid && !i_out_stall;

    // Last delivered result item, for comparing consecutive items.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prev <= o_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (w_take) begin
            r_have <= 1'b1;
        end
    end

    `IMU_CAF_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result item changed")
    `IMU_CAF_ASSERT(a_count_step, i_clk, i_rst_n, w_take && r_have |-> o_out_data.sample_count == r_prev.sample_count + 32'(o_out_data.updated), "sample count does not follow the updated flag")
    `IMU_CAF_ASSERT(a_idle_keeps, i_clk, i_rst_n, w_take && r_have && !o_out_data.updated |-> o_out_data.roll_angle == r_prev.roll_angle && o_out_data.pitch_angle == r_prev.pitch_angle && o_out_data.yaw_angle == r_prev.yaw_angle, "item without update changed the attitude")
    `IMU_CAF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset left a result or a full queue")

endmodule

bind imu_complementary_attitude_filter_unit imu_caf_checker u_chk (.*);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

class attitude_scoreboard;
    int unsigned errors;
    logic [15:0] weight;
    longint roll_q, pitch_q;
    logic [31:0] yaw_q, count_q;
    imu_caf_pkg::t_out_item pending[$];

    function new();
        errors = 0;
        weight = imu_caf_pkg::ALPHA_DEFAULT;
        roll_q = 0;
        pitch_q = 0;
        yaw_q = 0;
        count_q = 0;
    endfunction

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function longint round_shift(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    static function longint round_div(longint v, longint d);
        if (v >= 0) return (v + d / 2) / d;
        return -((-v + d / 2) / d);
    endfunction

    static function longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    static function longint tilt_atan2(longint y, longint x);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? imu_caf_pkg::PI_Q30 : -imu_caf_pkg::PI_Q30;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < imu_caf_pkg::CORDIC_ITER_DEF; i++) begin
            t = x;
            if (y > 0) begin
                x = x + floor_shift(y, i);
                y = y - floor_shift(t, i);
                z = z + longint'(imu_caf_pkg::atan_q30(i));
            end else begin
                x = x - floor_shift(y, i);
                y = y + floor_shift(t, i);
                z = z - longint'(imu_caf_pkg::atan_q30(i));
            end
        end
        return round_shift(z, 30 - imu_caf_pkg::ANGLE_FRAC_BITS_DEF);
    endfunction

    static function longint wrap_angle(longint v);
        longint p, tp, n;
        p = round_shift(imu_caf_pkg::PI_Q30, 30 - imu_caf_pkg::ANGLE_FRAC_BITS_DEF);
        tp = 2 * p;
        if (v > p) begin
            n = (v - p + tp - 1) / tp;
            v = v - n * tp;
        end
        if (v < -p) begin
            n = (-p - v + tp - 1) / tp;
            v = v + n * tp;
        end
        return v;
    endfunction

    static function longint rate_step(longint rate, longint us);
        return round_div(rate * us * (longint'(1) << imu_caf_pkg::ANGLE_FRAC_BITS_DEF),
                         imu_caf_pkg::GYRO_DIV);
    endfunction

    function longint fuse(longint a, longint g, longint acc);
        return wrap_angle(round_shift(a * g + (65536 - a) * acc, 16));
    endfunction

    function void note_sample(imu_caf_pkg::t_in_item s);
        imu_caf_pkg::t_out_item r;
        longint ax, ay, az, us, a, acc_roll, acc_pitch;
        ax = s.accel_x;
        ay = s.accel_y;
        az = s.accel_z;
        us = s.step_us;
        if (us != 0) begin
            a = (weight == 0) ? imu_caf_pkg::ALPHA_DEFAULT : weight;
            acc_roll = tilt_atan2(ay, az);
            acc_pitch = tilt_atan2(-ax, int_sqrt(ay * ay + az * az));
            roll_q = fuse(a, roll_q + rate_step(s.gyro_x, us), acc_roll);
            pitch_q = fuse(a, pitch_q + rate_step(s.gyro_y, us), acc_pitch);
            yaw_q = yaw_q + 32'(rate_step(s.gyro_z, us));
            count_q = count_q + 1;
        end
        r.roll_angle = 16'(roll_q);
        r.pitch_angle = 16'(pitch_q);
        r.yaw_angle = yaw_q;
        r.sample_count = count_q;
        r.updated = (us != 0);
        pending.push_back(r);
    endfunction

    function void check_result(imu_caf_pkg::t_out_item got);
        imu_caf_pkg::t_out_item e;
        if (pending.size() == 0) begin
            $error("result item with no sample pending");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.roll_angle !== e.roll_angle) begin
            $error("roll_angle expected %0d actual %0d", e.roll_angle, got.roll_angle);
            errors++;
        end
        if (got.pitch_angle !== e.pitch_angle) begin
            $error("pitch_angle expected %0d actual %0d", e.pitch_angle, got.pitch_angle);
            errors++;
        end
        if (got.yaw_angle !== e.yaw_angle) begin
            $error("yaw_angle expected %0d actual %0d", e.yaw_angle, got.yaw_angle);
            errors++;
        end
        if (got.sample_count !== e.sample_count) begin
            $error("sample_count expected %0d actual %0d", e.sample_count, got.sample_count);
            errors++;
        end
        if (got.updated !== e.updated) begin
            $error("updated expected %0d actual %0d", e.updated, got.updated);
            errors++;
        end
    endfunction
endclass

module testbench;
    import imu_caf_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    attitude_scoreboard board;
    longint cycle_count = 0;
    localparam longint CYCLE_LIMIT = 2000000;
    int stall_mode = 0;

    imu_complementary_attitude_filter_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_sample(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_data);
    end

    // Receiver stall pattern: off, light random, heavy random, periodic.
    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (cycle_count[3:0] < 5);
        endcase
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 3);
    end

    task automatic send_sample(t_in_item s);
        i_in_valid <= 1'b1;
        i_in_data <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        i_in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_weight(logic [15:0] w);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.weight = w;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_sample();
        t_in_item s;
        s.accel_x = pick16();
        s.accel_y = pick16();
        s.accel_z = pick16();
        s.gyro_x = pick16();
        s.gyro_y = pick16();
        s.gyro_z = pick16();
        case ($urandom_range(0, 9))
            0: s.step_us = 16'd0;
            1: s.step_us = 16'hFFFF;
            2: s.step_us = 16'($urandom);
            default: s.step_us = 16'($urandom_range(1, 2000));
        endcase
        return s;
    endfunction

    task automatic random_run(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0) begin
                send_sample(rand_sample());
                burst--;
                n--;
            end
            if ($urandom_range(0, 3) == 0) pause_sender();
        end
    endtask

    task automatic directed_run();
        t_in_item s;
        s = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF};
        send_sample(s);
        s = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF};
        send_sample(s);
        // All accelerometer axes zero gives both tilt angles zero.
        send_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'sd100, 16'd1000});
        // Negative z with zero y lands exactly on plus pi.
        send_sample('{16'sd0, 16'sd0, -16'sd128, 16'sd0, 16'sd0, 16'sd0, 16'd500});
        send_sample('{16'sd300, 16'sd0, -16'sd128, 16'sd0, 16'sd0, 16'sd0, 16'd500});
        // Zero time step leaves the state and clears the updated flag.
        send_sample('{16'sh1234, 16'sh4321, 16'sh7000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd0});
        send_sample('{-16'sd128, 16'sd128, 16'sd128, -16'sd1, 16'sd1, -16'sd1, 16'd1});
        send_sample('{16'sd0, 16'sd0, 16'sd1250, 16'sd0, 16'sd0, 16'sh7FFF, 16'hFFFF});
        repeat (8)
            send_sample('{16'sd0, 16'sd0, 16'sd1250, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                          16'hFFFF});
        repeat (4) send_sample(rand_sample());
    endtask

    initial begin
        board = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        directed_run();
        random_run(400);
        write_weight(16'd1);
        random_run(300);
        write_weight(16'hFFFF);
        random_run(300);
        // A zero weight falls back to the default blend.
        write_weight(16'd0);
        random_run(200);
        write_weight(16'($urandom_range(1, 65535)));
        random_run(200);
        write_weight(16'd32768);
        random_run(225);
        drain();
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/imu_caf_pkg.sv
hdl/imu_caf_front.sv
hdl/imu_caf_gstep.sv
hdl/imu_caf_tilt.sv
hdl/imu_caf_back.sv
hdl/imu_complementary_attitude_filter_unit.sv
hdl/imu_caf_checker.sv
test/testbench.sv
